// ----- rtl/lfgs_pkg.sv -----
// Shared types and constants for the life board generation step block.
package lfgs_pkg;

   localparam int COUNT_W   = 7;
   localparam int CSR_W     = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_STEP  = 2'd2,
      CMD_CHECK = 2'd3
   } cmd_type;

   typedef enum logic {
      REG_ROW_COUNT = 1'b0,
      REG_COL_COUNT = 1'b1
   } reg_index_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   // packed from the top bit down: cmd sits in the lowest bits
   typedef struct packed {
      logic       cell_value;
      logic [5:0] cell_col;
      logic [5:0] cell_row;
      cmd_type    cmd;
   } req_type;

endpackage

// ----- rtl/life_board_generation_step_core.sv -----
// Top level: life board held in a chain of row cells, rotated once per command.
//
//   channel  | direction | beat
//   req_     | in        | one command (write, read, step, check)
//   rsp_     | out       | one result per command
//   csr_     | in/out    | row_count at 0x0, col_count at 0x4
//
// Every command passes an accept state, then one full rotation of the row chain,
// one row through the update logic per cycle while the result is not stalled.
// The next command is taken as soon as the result sits in the output register.
// A stalled result holds the last rotation step until the output register frees up.
// Reset clears the whole board and sets both counts to 64.
module life_board_generation_step_core
   import lfgs_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // cmd, cell_row, cell_col, cell_value
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // read_value, stable
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_W-1:0]      csr_pwdata,
   output logic [CSR_W-1:0]      csr_prdata,
   output logic                  csr_pready
);

   localparam int RW  = $clog2(MAX_ROWS);
   localparam int RCW = ($clog2(MAX_ROWS + 1) > COUNT_W) ? $clog2(MAX_ROWS + 1) : COUNT_W;
   localparam int CIW = $clog2(MAX_COLS);

   logic [COUNT_W-1:0] row_count_ff;
   logic [COUNT_W-1:0] col_count_ff;
   logic               csr_write;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [RW-1:0]      row_idx_ff, row_idx_in;
   logic [MAX_COLS-1:0] prev_ff, prev_in;
   logic               same_ff, same_in;
   logic               rd_ff, rd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_read_ff, rsp_read_in;
   logic               rsp_stable_ff, rsp_stable_in;

   logic [MAX_COLS-1:0] rows_q [MAX_ROWS];
   logic [MAX_COLS-1:0] head_new;
   logic                shift_en;

   logic [RCW-1:0]      nr;
   logic [COUNT_W-1:0]  nc;
   logic [MAX_COLS-1:0] mask;
   logic [RCW-1:0]      idx_ext;
   logic                row_active;
   logic                hit;
   logic [MAX_COLS-1:0] up_word;
   logic [MAX_COLS-1:0] dn_word;
   logic [MAX_COLS-1:0] gen_word;
   logic                gen_changed;
   logic                last;
   logic                out_free;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= COUNT_RESET;
         col_count_ff <= COUNT_RESET;
      end else if (csr_write) begin
         case (reg_index_type'(csr_paddr[2]))
            REG_ROW_COUNT: row_count_ff <= csr_pwdata[COUNT_W-1:0];
            REG_COL_COUNT: col_count_ff <= csr_pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(csr_paddr[2]))
         REG_ROW_COUNT: csr_prdata = CSR_W'(row_count_ff);
         REG_COL_COUNT: csr_prdata = CSR_W'(col_count_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // active area
   always_comb begin
      nr = (RCW'(row_count_ff) > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(row_count_ff);
      nc = (col_count_ff > COUNT_W'(MAX_COLS)) ? COUNT_W'(MAX_COLS) : col_count_ff;
      for (int c = 0; c < MAX_COLS; c++) begin
         mask[c] = COUNT_W'(c) < nc;
      end
   end

   // row chain
   for (genvar i = 0; i < MAX_ROWS; i++) begin : g_row
      if (i == MAX_ROWS - 1) begin : g_tail
         lfgs_row_cell #(.WIDTH(MAX_COLS)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .word_in  (head_new),
            .word_out (rows_q[i])
         );
      end else begin : g_mid
         lfgs_row_cell #(.WIDTH(MAX_COLS)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .word_in  (rows_q[i+1]),
            .word_out (rows_q[i])
         );
      end
   end

   // window around the head row
   always_comb begin
      idx_ext    = RCW'(row_idx_ff);
      row_active = idx_ext < nr;
      up_word    = (row_idx_ff != '0) ? (prev_ff & mask) : '0;
      dn_word    = ((idx_ext + RCW'(1)) < nr) ? (rows_q[1] & mask) : '0;
      hit        = (idx_ext == RCW'(req_ff.cell_row))
                && (RCW'(req_ff.cell_row) < nr)
                && ({1'b0, req_ff.cell_col} < nc);
   end

   lfgs_row_next #(.WIDTH(MAX_COLS)) u_next (
      .up_word   (up_word),
      .cur_word  (rows_q[0]),
      .dn_word   (dn_word),
      .col_mask  (mask),
      .next_word (gen_word),
      .changed   (gen_changed)
   );

   always_comb begin
      head_new = rows_q[0];
      case (req_ff.cmd)
         CMD_WRITE: begin
            if (hit) begin
               head_new[req_ff.cell_col[CIW-1:0]] = req_ff.cell_value;
            end
         end
         CMD_STEP: begin
            if (row_active) begin
               head_new = gen_word;
            end
         end
         default: ;
      endcase
   end

   // control
   assign last     = row_idx_ff == RW'(MAX_ROWS - 1);
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         row_idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         row_idx_ff   <= row_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      prev_ff       <= prev_in;
      same_ff       <= same_in;
      rd_ff         <= rd_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_stable_ff <= rsp_stable_in;
   end

   always_comb begin
      logic rd_cur;
      logic same_cur;
      state_in      = state_ff;
      req_in        = req_ff;
      row_idx_in    = row_idx_ff;
      prev_in       = prev_ff;
      same_in       = same_ff;
      rd_in         = rd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_read_in   = rsp_read_ff;
      rsp_stable_in = rsp_stable_ff;
      req_tready    = 1'b0;
      shift_en      = 1'b0;
      rd_cur        = rd_ff;
      same_cur      = same_ff;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               req_in     = req_type'(req_tdata[14:0]);
               row_idx_in = '0;
               same_in    = 1'b1;
               rd_in      = 1'b0;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            shift_en = !last || out_free;
            if (req_ff.cmd == CMD_READ && hit) begin
               rd_cur = rows_q[0][req_ff.cell_col[CIW-1:0]];
            end
            if ((req_ff.cmd == CMD_STEP || req_ff.cmd == CMD_CHECK)
                && row_active && gen_changed) begin
               same_cur = 1'b0;
            end
            if (shift_en) begin
               prev_in    = rows_q[0];
               rd_in      = rd_cur;
               same_in    = same_cur;
               row_idx_in = last ? '0 : row_idx_ff + RW'(1);
               if (last) begin
                  rsp_valid_in  = 1'b1;
                  rsp_read_in   = (req_ff.cmd == CMD_READ) && rd_cur;
                  rsp_stable_in = (req_ff.cmd == CMD_STEP || req_ff.cmd == CMD_CHECK)
                                && same_cur;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_stable_ff, rsp_read_ff};

endmodule

// ----- rtl/lfgs_row_cell.sv -----
// One row cell of the board chain: holds a row word and takes its neighbor's word on shift.
module lfgs_row_cell
   import lfgs_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  logic [WIDTH-1:0] word_in,
   output logic [WIDTH-1:0] word_out
);

   logic [WIDTH-1:0] word_ff;
   logic [WIDTH-1:0] word_in_nxt;

   always_comb begin
      word_in_nxt = shift_en ? word_in : word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
      end else begin
         word_ff <= word_in_nxt;
      end
   end

   assign word_out = word_ff;

endmodule

// ----- rtl/lfgs_row_next.sv -----
// B3/S23 next-generation logic for one row from its three-row window.
module lfgs_row_next
   import lfgs_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  logic [WIDTH-1:0] up_word,
   input  logic [WIDTH-1:0] cur_word,
   input  logic [WIDTH-1:0] dn_word,
   input  logic [WIDTH-1:0] col_mask,
   output logic [WIDTH-1:0] next_word,
   output logic             changed
);

   logic [WIDTH+1:0] up_pad;
   logic [WIDTH+1:0] cur_pad;
   logic [WIDTH+1:0] dn_pad;
   logic [WIDTH-1:0] born;
   logic [WIDTH-1:0] cur_act;

   always_comb begin
      logic [3:0] n;
      cur_act = cur_word & col_mask;
      up_pad  = {1'b0, up_word, 1'b0};
      cur_pad = {1'b0, cur_act, 1'b0};
      dn_pad  = {1'b0, dn_word, 1'b0};
      for (int c = 0; c < WIDTH; c++) begin
         n = 4'(up_pad[c]) + 4'(up_pad[c+1]) + 4'(up_pad[c+2])
           + 4'(cur_pad[c]) + 4'(cur_pad[c+2])
           + 4'(dn_pad[c]) + 4'(dn_pad[c+1]) + 4'(dn_pad[c+2]);
         born[c] = (n == BIRTH_COUNT) || (cur_act[c] && (n == SURVIVE_COUNT));
      end
      next_word = (cur_word & ~col_mask) | (born & col_mask);
      changed   = |((born ^ cur_word) & col_mask);
   end

endmodule

// ----- sim/life_board_generation_step_core_tb.sv -----
// Testbench for life_board_generation_step_core: directed and random commands vs. a board predictor.
module life_board_generation_step_core_tb
   import lfgs_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int BOARD_ROWS = 64;
   localparam int BOARD_COLS = 64;
   localparam int QUIET_LIMIT = 5000;

   typedef struct {
      logic read_value;
      logic stable;
   } cell_report_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata = '0;   // cmd, cell_row, cell_col, cell_value
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;        // read_value, stable
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_W-1:0]      csr_pwdata = '0;
   logic [CSR_W-1:0]      csr_prdata;
   logic                  csr_pready;

   logic [BOARD_COLS-1:0] board [BOARD_ROWS];
   logic [COUNT_W-1:0]    rows_set = COUNT_RESET;
   logic [COUNT_W-1:0]    cols_set = COUNT_RESET;
   cell_report_type       cell_reports [$];
   cell_report_type       oldest;
   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;
   int                    error_count = 0;
   int                    quiet_cycles = 0;

   life_board_generation_step_core #(
      .MAX_ROWS (BOARD_ROWS),
      .MAX_COLS (BOARD_COLS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------- board predictor ----------------
   function automatic int live_rows();
      return (rows_set > BOARD_ROWS) ? BOARD_ROWS : int'(rows_set);
   endfunction

   function automatic int live_cols();
      return (cols_set > BOARD_COLS) ? BOARD_COLS : int'(cols_set);
   endfunction

   // next generation of the active area; cells outside it are kept
   function automatic logic advance_board(input bit commit);
      logic [BOARD_COLS-1:0] nxt [BOARD_ROWS];
      int   nr, nc, n, rr, cc;
      logic same, alive, nv;
      nr = live_rows();
      nc = live_cols();
      same = 1'b1;
      nxt = board;
      for (int r = 0; r < nr; r++) begin
         for (int c = 0; c < nc; c++) begin
            n = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  rr = r + dr;
                  cc = c + dc;
                  if ((dr != 0 || dc != 0) && rr >= 0 && rr < nr && cc >= 0 && cc < nc)
                     n += int'(board[rr][cc]);
               end
            end
            alive = board[r][c];
            nv = (n == int'(BIRTH_COUNT)) || (alive && n == int'(SURVIVE_COUNT));
            nxt[r][c] = nv;
            if (nv != alive) same = 1'b0;
         end
      end
      if (commit) board = nxt;
      return same;
   endfunction

   function automatic cell_report_type board_apply(input cmd_type cmd, input logic [5:0] row,
                                                   input logic [5:0] col, input logic val);
      cell_report_type rep;
      bit              in_area;
      rep.read_value = 1'b0;
      rep.stable = 1'b0;
      in_area = (int'(row) < live_rows()) && (int'(col) < live_cols());
      case (cmd)
         CMD_WRITE: begin
            if (in_area) board[row][col] = val;
         end
         CMD_READ: begin
            if (in_area) rep.read_value = board[row][col];
         end
         CMD_STEP: begin
            rep.stable = advance_board(1'b1);
         end
         default: begin
            rep.stable = advance_board(1'b0);
         end
      endcase
      return rep;
   endfunction

   // ---------------- drivers ----------------
   task automatic send_cmd(input cmd_type cmd, input logic [5:0] row,
                           input logic [5:0] col, input logic val);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, val, col, row, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      cell_reports.push_back(board_apply(cmd, row, col, val));
   endtask

   task automatic quiesce();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (cell_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [COUNT_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= CSR_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (idx == REG_ROW_COUNT) rows_set = value;
      else cols_set = value;
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== CSR_W'(value)) begin
         $error("prdata expected %0d actual %0d", value, csr_prdata);
         error_count++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_board_size(input logic [COUNT_W-1:0] rows, input logic [COUNT_W-1:0] cols);
      quiesce();
      csr_write(REG_ROW_COUNT, rows);
      csr_write(REG_COL_COUNT, cols);
   endtask

   // ---------------- receiver, checker, watchdog ----------------
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (cell_reports.size() == 0) begin
            $error("result beat with nothing pending, rsp_tdata=%h", rsp_tdata);
            error_count++;
         end else begin
            oldest = cell_reports.pop_front();
            if (rsp_tdata[0] !== oldest.read_value) begin
               $error("read_value expected %0d actual %0d", oldest.read_value, rsp_tdata[0]);
               error_count++;
            end
            if (rsp_tdata[1] !== oldest.stable) begin
               $error("stable expected %0d actual %0d", oldest.stable, rsp_tdata[1]);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------- tests ----------------
   task automatic test_empty_board();
      send_cmd(CMD_CHECK, 6'd0, 6'd0, 1'b0);
      send_cmd(CMD_READ, 6'd0, 6'd0, 1'b0);
      send_cmd(CMD_STEP, 6'd63, 6'd63, 1'b1);
   endtask

   task automatic test_corner_cells();
      send_cmd(CMD_WRITE, 6'd0, 6'd0, 1'b1);
      send_cmd(CMD_WRITE, 6'd63, 6'd63, 1'b1);
      send_cmd(CMD_WRITE, 6'd0, 6'd63, 1'b1);
      send_cmd(CMD_WRITE, 6'd63, 6'd0, 1'b1);
      send_cmd(CMD_READ, 6'd63, 6'd63, 1'b0);
      send_cmd(CMD_READ, 6'd0, 6'd63, 1'b0);
      send_cmd(CMD_STEP, 6'd0, 6'd0, 1'b0);
      send_cmd(CMD_READ, 6'd0, 6'd0, 1'b0);
   endtask

   // blinker on the top edge: no wrap to the bottom row
   task automatic test_edge_blinker();
      for (int c = 1; c <= 3; c++) send_cmd(CMD_WRITE, 6'd0, 6'(c), 1'b1);
      send_cmd(CMD_CHECK, 6'd0, 6'd0, 1'b0);
      send_cmd(CMD_STEP, 6'd0, 6'd0, 1'b0);
      send_cmd(CMD_READ, 6'd1, 6'd2, 1'b0);
      send_cmd(CMD_WRITE, 6'd1, 6'd2, 1'b0);
   endtask

   // out-of-range cells, hidden cells, zero size and oversize counts
   task automatic test_size_limits();
      send_cmd(CMD_WRITE, 6'd5, 6'd5, 1'b1);
      set_board_size(7'd3, 7'd3);
      send_cmd(CMD_WRITE, 6'd4, 6'd1, 1'b1);
      send_cmd(CMD_READ, 6'd5, 6'd5, 1'b0);
      send_cmd(CMD_STEP, 6'd0, 6'd0, 1'b0);
      set_board_size(7'd0, 7'd0);
      send_cmd(CMD_WRITE, 6'd0, 6'd0, 1'b1);
      send_cmd(CMD_READ, 6'd0, 6'd0, 1'b0);
      send_cmd(CMD_CHECK, 6'd0, 6'd0, 1'b0);
      set_board_size(7'd127, 7'd127);
      send_cmd(CMD_READ, 6'd5, 6'd5, 1'b0);
      set_board_size(7'd1, 7'd64);
      send_cmd(CMD_STEP, 6'd0, 6'd0, 1'b0);
   endtask

   task automatic pick_size(output logic [COUNT_W-1:0] sz);
      case ($urandom_range(9))
         0: sz = 7'd0;
         1: sz = 7'd1;
         2: sz = 7'd64;
         3: sz = 7'd127;
         4: sz = COUNT_W'($urandom_range(127));
         default: sz = COUNT_W'($urandom_range(10, 3));
      endcase
   endtask

   function automatic logic [5:0] pick_coord(input int span);
      if (span == 0 || $urandom_range(99) < 15) return 6'($urandom_range(63));
      return 6'($urandom_range(span - 1));
   endfunction

   // sizing, a burst of writes, then a run of steps, checks and reads
   task automatic test_random(input int send_pct, input int recv_pct, input int items);
      logic [COUNT_W-1:0] rs, cs;
      int                 done;
      done = 0;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      while (done < items) begin
         pick_size(rs);
         pick_size(cs);
         set_board_size(rs, cs);
         repeat ($urandom_range(16, 3)) begin
            send_cmd(CMD_WRITE, pick_coord(live_rows()), pick_coord(live_cols()),
                     1'($urandom_range(99) < 65));
            done++;
         end
         repeat ($urandom_range(8, 2)) begin
            case ($urandom_range(9))
               0, 1, 2, 3: send_cmd(CMD_STEP, 6'($urandom_range(63)), 6'($urandom_range(63)),
                                    1'($urandom_range(1)));
               4, 5: send_cmd(CMD_CHECK, 6'($urandom_range(63)), 6'($urandom_range(63)),
                              1'($urandom_range(1)));
               6, 7, 8: send_cmd(CMD_READ, pick_coord(live_rows()), pick_coord(live_cols()),
                                 1'($urandom_range(1)));
               default: send_cmd(cmd_type'($urandom_range(3)), 6'($urandom_range(63)),
                                 6'($urandom_range(63)), 1'($urandom_range(1)));
            endcase
            done++;
         end
      end
   endtask

   initial begin
      for (int r = 0; r < BOARD_ROWS; r++) board[r] = '0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 33;
      recv_idle_pct = 53;
      test_empty_board();
      test_corner_cells();
      test_edge_blinker();
      test_size_limits();
      test_random(33, 53, 120);
      test_random(53, 33, 120);
      test_random(0, 0, 120);
      quiesce();
      repeat (BOARD_ROWS + 8) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
